### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers for the diagonal preconditioner RTL. They expect
// i_clk and i_rst_n in scope and can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// The property must hold at every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
// The condition must never be true outside of reset.
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

### src/sdp_pkg.sv
// ----------------------------------------------------------------------------
// Diagonal preconditioner package
// Widths, limits and the divider result type shared by the RTL modules.
// ----------------------------------------------------------------------------
package sdp_pkg;

    localparam int COL_W     = 20;        // row and column index width
    localparam int VAL_W     = 32;        // Q16.16 entry and weight width
    localparam int NORM_W    = 64;        // norm accumulator width
    localparam int DIAG_W    = 48;        // diagonal accumulator width
    localparam int MAX_DIM   = 1048576;   // number of columns before wrap
    localparam int DIV_STEPS = 32;        // quotient bits produced by the divider

    localparam logic [VAL_W-1:0] W_POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] W_NEG_MAX = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic             done;      // one-cycle pulse, result below is valid
        logic             too_big;   // quotient is 2^32 or more
        logic [VAL_W-1:0] quot;      // floor(num * 2^32 / den)
    } t_div_res;

endpackage

### src/sdp_divider.sv
// ----------------------------------------------------------------------------
// Scaled restoring divider
// Computes floor(num * 2^32 / den) one quotient bit per cycle; flags results
// that do not fit in 32 bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdp_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sdp_pkg::DIAG_W-1:0]   i_num,
    input  logic [sdp_pkg::NORM_W-1:0]   i_den,
    output sdp_pkg::t_div_res            o_res
);
    import sdp_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_big;
    logic [NORM_W-1:0]   r_rem;
    logic [NORM_W-1:0]   r_den;
    logic [VAL_W-1:0]    r_quo;

    logic [NORM_W-1:0]   num_ext;
    logic [NORM_W:0]     rem_x2;
    logic [NORM_W:0]     diff;

    assign num_ext = {{(NORM_W-DIAG_W){1'b0}}, i_num};
    assign rem_x2  = {r_rem, 1'b0};
    assign diff    = rem_x2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                r_quo <= '0;
                r_rem <= num_ext;
                r_cnt <= '0;
                // The remainder must start below the divisor, else the
                // quotient cannot fit.
                if (num_ext >= i_den) begin
                    r_big  <= 1'b1;
                    r_done <= 1'b1;
                end else begin
                    r_big  <= 1'b0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (!diff[NORM_W]) begin
                    r_rem <= diff[NORM_W-1:0];
                    r_quo <= {r_quo[VAL_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_x2[NORM_W-1:0];
                    r_quo <= {r_quo[VAL_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done    = r_done;
    assign o_res.too_big = r_big;
    assign o_res.quot    = r_quo;

    `ASSERT_NEVER(a_start_while_busy, i_start && r_busy)
    `ASSERT_CLK(a_done_has_origin, r_done |-> ($past(r_busy) || $past(i_start)))
    `ASSERT_CLK(a_rem_below_den, r_busy |-> (r_rem < r_den))

endmodule

### src/sparse_diag_preconditioner_unit.sv
// ----------------------------------------------------------------------------
// Sparse diagonal preconditioner unit
// Streams sparse matrix entries column by column and emits one L1-Jacobi or
// SPAI-0 weight per column end.
// ----------------------------------------------------------------------------
// An entry that does not close a column is accepted, passes S_MUL, where
// the 32x32 multiplier squares it in SPAI mode, and is accumulated in
// S_ADD; an empty column marker goes straight to the column end. A column
// end adds a check in S_END and, when the norm is nonzero, the bit-serial
// divider in S_DIV (one quotient bit per cycle, no steps when the quotient
// cannot fit), then loads the output register in S_OUT. The divider's 32
// steps set the cost of a column end that runs a full division. The
// input side stalls while an item is in work; a finished weight waits in
// the output register while the next entries are taken, and a column end
// that finds that register still full holds until it drains. Mode is to be
// written only while the unit is idle; the unit itself does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sparse_diag_preconditioner_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_mode,
    // entry requests
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [sdp_pkg::COL_W-1:0]   i_row_index,
    input  logic signed [sdp_pkg::VAL_W-1:0] i_entry_value,
    input  logic                        i_column_last,
    input  logic                        i_column_empty,
    // weight results
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [sdp_pkg::COL_W-1:0]   o_column_number,
    output logic signed [sdp_pkg::VAL_W-1:0] o_weight,
    output logic                        o_saturated
);
    import sdp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_END  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]               r_state;
    logic                     r_mode;
    logic [COL_W-1:0]         r_col;
    logic [NORM_W-1:0]        r_norm;
    logic signed [DIAG_W-1:0] r_diag;
    logic                     r_ovf;

    logic [VAL_W-1:0]         r_mag;
    logic signed [VAL_W-1:0]  r_val;
    logic                     r_hit;
    logic                     r_last;
    logic [NORM_W-1:0]        r_term;
    logic [VAL_W-1:0]         r_wt;
    logic                     r_wsat;

    logic                     r_o_valid;
    logic [COL_W-1:0]         r_o_col;
    logic [VAL_W-1:0]         r_o_wt;
    logic                     r_o_sat;

    logic                     in_take;
    logic                     out_free;
    logic [VAL_W-1:0]         in_mag;
    logic [NORM_W:0]          norm_sum;
    logic signed [DIAG_W:0]   diag_sum;
    logic                     diag_clip;
    logic                     diag_neg;
    logic [DIAG_W-1:0]        diag_mag;
    logic                     div_start;
    logic [DIAG_W-1:0]        div_num;
    t_div_res                 div_res;
    logic                     q_clip;
    logic [VAL_W-1:0]         q_wt;

    assign in_take  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_o_valid || !i_stall;

    assign in_mag = i_entry_value[VAL_W-1] ? (VAL_W'(0) - i_entry_value) : i_entry_value;

    assign norm_sum  = {1'b0, r_norm} + {1'b0, r_term};
    assign diag_sum  = {r_diag[DIAG_W-1], r_diag}
                     + {{(DIAG_W+1-VAL_W){r_val[VAL_W-1]}}, r_val};
    assign diag_clip = diag_sum[DIAG_W] != diag_sum[DIAG_W-1];

    assign diag_neg  = r_diag[DIAG_W-1];
    assign diag_mag  = diag_neg ? (DIAG_W'(0) - r_diag) : r_diag;
    assign div_start = (r_state == S_END) && (r_norm != '0);
    assign div_num   = r_mode ? diag_mag : DIAG_W'(1);

    sdp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_norm),
        .o_res   (div_res)
    );

    // A negative SPAI weight may reach -2^31; everything else stops at 2^31-1.
    always_comb begin
        if (r_mode && diag_neg) begin
            q_clip = div_res.too_big || (div_res.quot[VAL_W-1] && |div_res.quot[VAL_W-2:0]);
            q_wt   = q_clip ? W_NEG_MAX : (VAL_W'(0) - div_res.quot);
        end else begin
            q_clip = div_res.too_big || div_res.quot[VAL_W-1];
            q_wt   = q_clip ? W_POS_MAX : div_res.quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= 1'b0;
            r_col     <= '0;
            r_norm    <= '0;
            r_diag    <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_mode;
            end
            if ((r_state == S_OUT) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_mag  <= in_mag;
                        r_val  <= i_entry_value;
                        r_hit  <= i_row_index == r_col;
                        r_last <= i_column_last;
                        r_state <= i_column_empty ? S_END : S_MUL;
                    end
                end
                S_MUL: begin
                    r_term  <= r_mode ? (NORM_W'(r_mag) * NORM_W'(r_mag)) : NORM_W'(r_mag);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (norm_sum[NORM_W]) begin
                        r_norm <= '1;
                        r_ovf  <= 1'b1;
                    end else begin
                        r_norm <= norm_sum[NORM_W-1:0];
                    end
                    if (r_hit) begin
                        if (diag_clip) begin
                            r_diag <= diag_sum[DIAG_W] ? {1'b1, {(DIAG_W-1){1'b0}}}
                                                       : {1'b0, {(DIAG_W-1){1'b1}}};
                            r_ovf  <= 1'b1;
                        end else begin
                            r_diag <= diag_sum[DIAG_W-1:0];
                        end
                    end
                    r_state <= r_last ? S_END : S_IDLE;
                end
                S_END: begin
                    if (r_norm == '0) begin
                        r_wt    <= '0;
                        r_wsat  <= r_ovf;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_res.done) begin
                        r_wt    <= q_wt;
                        r_wsat  <= r_ovf || q_clip;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_col   <= r_col;
                        r_o_wt    <= r_wt;
                        r_o_sat   <= r_wsat;
                        r_col     <= (r_col == COL_W'(MAX_DIM-1)) ? '0 : r_col + 1'b1;
                        r_norm    <= '0;
                        r_diag    <= '0;
                        r_ovf     <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall         = r_state != S_IDLE;
    assign o_valid         = r_o_valid;
    assign o_column_number = r_o_col;
    assign o_weight        = r_o_wt;
    assign o_saturated     = r_o_sat;

    `ASSERT_CLK(a_div_nonzero_norm, (r_state == S_DIV) |-> (r_norm != '0))
    `ASSERT_CLK(a_result_from_out, (r_o_valid && !$past(r_o_valid)) |-> $past(r_state == S_OUT))
    `ASSERT_CLK(a_col_steps_on_result, ($past(i_rst_n) && (r_col != $past(r_col))) |-> ($past(r_state == S_OUT) && r_o_valid))
    `ASSERT_NEVER(a_done_outside_div, div_res.done && (r_state != S_DIV))

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse diagonal preconditioner unit testbench
// Drives column-ordered sparse entries into the unit and checks every weight
// against a cycle-free prediction. The prediction keeps its own column
// counter, norm and diagonal sums. Directed columns cover zero norms, empty
// and double-flagged column ends, saturation in both modes, and a mode switch
// inside an open column. They are followed by random columns under three idle
// patterns and one long hold on the output side.
// ----------------------------------------------------------------------------
module testbench;
    import sdp_pkg::*;

    localparam logic       MODE_L1       = 1'b0;
    localparam logic       MODE_SPAI     = 1'b1;
    localparam logic [31:0] Q_ONE        = 32'h0001_0000;
    localparam longint     DIAG_HI       = (longint'(1) <<< (DIAG_W - 1)) - 1;
    localparam longint     DIAG_LO       = -(longint'(1) <<< (DIAG_W - 1));
    localparam int         SETTLE_CYCLES = 80;
    localparam int         HOLD_CYCLES   = 600;
    localparam int         CYCLE_LIMIT   = 3_000_000;

    typedef struct packed {
        logic [COL_W-1:0] row;
        logic [VAL_W-1:0] value;
        logic             last;
        logic             empty;
    } t_col_entry;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [VAL_W-1:0] weight;
        logic             sat;
    } t_weight;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_we       = 1'b0;
    logic                    i_cfg_mode     = 1'b0;
    logic                    i_valid        = 1'b0;
    logic                    o_stall;
    logic [COL_W-1:0]        i_row_index    = '0;
    logic signed [VAL_W-1:0] i_entry_value  = '0;
    logic                    i_column_last  = 1'b0;
    logic                    i_column_empty = 1'b0;
    logic                    o_valid;
    logic                    i_stall        = 1'b0;
    logic [COL_W-1:0]        o_column_number;
    logic signed [VAL_W-1:0] o_weight;
    logic                    o_saturated;

    sparse_diag_preconditioner_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_mode      (i_cfg_mode),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_row_index     (i_row_index),
        .i_entry_value   (i_entry_value),
        .i_column_last   (i_column_last),
        .i_column_empty  (i_column_empty),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_column_number (o_column_number),
        .o_weight        (o_weight),
        .o_saturated     (o_saturated)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and expected weights.
    t_col_entry entry_queue[$];
    t_weight    pending_weights[$];
    int         items_queued    = 0;
    int         items_accepted  = 0;
    int         weights_checked = 0;
    int         sat_weights     = 0;
    int         error_count     = 0;
    int         send_idle_pct   = 0;
    int         recv_idle_pct   = 0;
    int         hold_left       = 0;
    logic       hold_start      = 1'b0;
    int         cycle_count     = 0;
    logic [COL_W-1:0] gen_column = '0;

    // Predicted unit state.
    logic                     mode_q     = MODE_L1;
    logic [COL_W-1:0]         col_count  = '0;
    logic [NORM_W-1:0]        norm_sum   = '0;
    logic signed [DIAG_W-1:0] diag_sum   = '0;
    logic                     clip_seen  = 1'b0;

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    // floor(num * 2^32 / den); all ones when the quotient reaches 2^32.
    function automatic logic [127:0] fixed_ratio(input logic [63:0] num,
                                                 input logic [63:0] den);
        if (num >= den)
            return '1;
        return ({64'd0, num} << 32) / {64'd0, den};
    endfunction

    task automatic accumulate_entry(input logic [COL_W-1:0] row,
                                    input logic [VAL_W-1:0] value,
                                    input logic last, input logic empty);
        longint            v;
        longint            d;
        longint            dd;
        logic [63:0]       mag;
        logic [63:0]       addend;
        logic [63:0]       dmag;
        logic [64:0]       nsum;
        logic [127:0]      q;
        logic              sat;
        logic [VAL_W-1:0]  w;
        if (!empty) begin
            v = $signed(value);
            mag = (v < 0) ? 64'(-v) : 64'(v);
            addend = (mode_q == MODE_SPAI) ? mag * mag : mag;
            nsum = {1'b0, norm_sum} + {1'b0, addend};
            if (nsum[64]) begin
                norm_sum = '1;
                clip_seen = 1'b1;
            end else begin
                norm_sum = nsum[63:0];
            end
            if (row == col_count) begin
                dd = diag_sum;
                d = dd + v;
                if (d > DIAG_HI) begin
                    d = DIAG_HI;
                    clip_seen = 1'b1;
                end else if (d < DIAG_LO) begin
                    d = DIAG_LO;
                    clip_seen = 1'b1;
                end
                diag_sum = DIAG_W'(d);
            end
            if (!last)
                return;
        end

        // Column end: form the weight under the mode in force now.
        sat = clip_seen;
        w = '0;
        if (norm_sum != 0) begin
            if (mode_q == MODE_L1) begin
                q = fixed_ratio(64'd1, norm_sum);
                if (q > 128'h7FFF_FFFF) begin
                    w = W_POS_MAX;
                    sat = 1'b1;
                end else begin
                    w = q[VAL_W-1:0];
                end
            end else begin
                dd = diag_sum;
                dmag = (dd < 0) ? 64'(-dd) : 64'(dd);
                q = fixed_ratio(dmag, norm_sum);
                if (dd < 0) begin
                    if (q > 128'h8000_0000) begin
                        q = 128'h8000_0000;
                        sat = 1'b1;
                    end
                    w = VAL_W'(0) - q[VAL_W-1:0];
                end else if (q > 128'h7FFF_FFFF) begin
                    w = W_POS_MAX;
                    sat = 1'b1;
                end else begin
                    w = q[VAL_W-1:0];
                end
            end
        end
        pending_weights.push_back('{column: col_count, weight: w, sat: sat});
        col_count = col_count + 1'b1;
        norm_sum = '0;
        diag_sum = '0;
        clip_seen = 1'b0;
    endtask

    // Request driver: holds the payload while stalled, idles at random otherwise.
    always @(posedge i_clk) begin : driver
        t_col_entry nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                accumulate_entry(i_row_index, i_entry_value, i_column_last, i_column_empty);
                items_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (entry_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = entry_queue.pop_front();
                    i_row_index    <= nxt.row;
                    i_entry_value  <= nxt.value;
                    i_column_last  <= nxt.last;
                    i_column_empty <= nxt.empty;
                    i_valid        <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold, counted apart from the random stalls.
    always @(posedge i_clk) begin
        if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin : monitor
        t_weight want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_weights.size() == 0) begin
                    report_mismatch($sformatf("weight for column %0d with none pending",
                                              o_column_number));
                end else begin
                    want = pending_weights.pop_front();
                    if (o_column_number !== want.column)
                        report_mismatch($sformatf("column %0d, wanted %0d",
                                                  o_column_number, want.column));
                    if (o_weight !== want.weight)
                        report_mismatch($sformatf("column %0d weight %h, wanted %h",
                                                  want.column, o_weight, want.weight));
                    if (o_saturated !== want.sat)
                        report_mismatch($sformatf("column %0d saturated %b, wanted %b",
                                                  want.column, o_saturated, want.sat));
                    weights_checked++;
                    if (o_saturated)
                        sat_weights++;
                end
            end
            i_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_entry(input logic [COL_W-1:0] row, input logic [VAL_W-1:0] value,
                             input logic last, input logic empty);
        entry_queue.push_back('{row: row, value: value, last: last, empty: empty});
        items_queued++;
        if (last || empty)
            gen_column = gen_column + 1'b1;
    endtask

    // Rows lean toward the diagonal so that the diagonal sum sees real traffic.
    function automatic logic [COL_W-1:0] pick_row();
        case ($urandom_range(9))
            0, 1, 2, 3: return gen_column;
            4:          return gen_column + 1'b1;
            5:          return gen_column - 1'b1;
            default:    return COL_W'($urandom_range(20'hFFFFF));
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return W_NEG_MAX;
            1:       return W_POS_MAX;
            2:       return $urandom_range(1, 32'h0003_0000);
            3:       return 32'd0 - $urandom_range(1, 32'h0003_0000);
            4:       return '0;
            5:       return 32'($urandom_range(0, 4)) - 32'd2;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random_column();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 8) begin
            add_entry(COL_W'($urandom), $urandom, 1'($urandom_range(1)), 1'b1);
        end else if (kind < 15) begin
            // Entries closed only by an empty marker.
            n = $urandom_range(1, 4);
            repeat (n) add_entry(pick_row(), pick_value(), 1'b0, 1'b0);
            add_entry(COL_W'($urandom), $urandom, 1'($urandom_range(1)), 1'b1);
        end else if (kind < 22) begin
            // Extreme magnitudes push the norm toward its limit, squared in SPAI mode.
            n = $urandom_range(4, 8);
            for (int k = 0; k < n; k++)
                add_entry(pick_row(), $urandom_range(1) ? W_NEG_MAX : W_POS_MAX,
                          k == n - 1, 1'b0);
        end else begin
            n = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
                add_entry(pick_row(), pick_value(), k == n - 1,
                          (k == n - 1) && ($urandom_range(19) == 0));
        end
    endtask

    task automatic queue_random_items(input int n);
        int stop;
        stop = items_queued + n;
        while (items_queued < stop)
            queue_random_column();
        // Often leave a column open so the next mode applies part way through it.
        if ($urandom_range(1))
            repeat ($urandom_range(1, 3)) add_entry(pick_row(), pick_value(), 1'b0, 1'b0);
    endtask

    task automatic wait_idle();
        while (items_accepted != items_queued || pending_weights.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_mode <= m;
        mode_q = m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    initial begin : stimulus
        int seg;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idle(13, 49);

        write_mode(MODE_L1);
        add_entry(0, Q_ONE, 1'b1, 1'b0);
        add_entry(0, '0, 1'b0, 1'b1);
        add_entry(2, '0, 1'b1, 1'b0);
        add_entry(3, 32'd1, 1'b1, 1'b0);
        add_entry(4, W_NEG_MAX, 1'b0, 1'b0);
        add_entry(20'hFFFFF, W_POS_MAX, 1'b1, 1'b0);
        add_entry(5, 32'hFFFF_0000, 1'b0, 1'b0);
        add_entry(20'hFFFFF, 32'h0002_8000, 1'b0, 1'b0);
        add_entry(5, W_POS_MAX, 1'b1, 1'b1);
        add_entry(6, 32'h0003_0000, 1'b0, 1'b0);
        add_entry(20'hFFFFF, W_NEG_MAX, 1'b0, 1'b1);
        add_entry(7, 32'h0000_8000, 1'b0, 1'b0);
        wait_idle();

        // Column 7 is still open and closes under the other mode.
        write_mode(MODE_SPAI);
        add_entry(7, 32'hFFFF_C000, 1'b1, 1'b0);
        repeat (4) add_entry(8, W_NEG_MAX, 1'b0, 1'b0);
        add_entry(8, W_NEG_MAX, 1'b1, 1'b0);
        add_entry(9, W_POS_MAX, 1'b1, 1'b0);
        add_entry(10, 32'd1, 1'b1, 1'b0);
        add_entry(11, 32'hFFFF_FFFF, 1'b1, 1'b0);
        add_entry(12, 32'hFFFF_FFFE, 1'b1, 1'b0);
        add_entry(0, Q_ONE, 1'b1, 1'b0);
        add_entry(14, Q_ONE, 1'b1, 1'b1);
        wait_idle();

        for (seg = 0; seg < 6; seg++) begin
            if (seg < 2)
                set_idle(13, 49);
            else if (seg < 4)
                set_idle(49, 13);
            else
                set_idle(0, 0);
            write_mode((seg % 2 == 0) ? MODE_SPAI : MODE_L1);
            queue_random_items(285);
            wait_idle();
        end

        // The output side holds off while requests keep coming.
        write_mode(MODE_SPAI);
        queue_random_items(80);
        @(posedge i_clk);
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        wait_idle();

        $display("Sent %0d entries in L1 and SPAI modes; checked %0d weights, %0d saturated.",
                 items_accepted, weights_checked, sat_weights);
        $display("Idle mixes on both sides and one long output hold that backs up requests.");
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sparse_diag_preconditioner_unit.f
+incdir+src
src/sdp_pkg.sv
src/sdp_divider.sv
src/sparse_diag_preconditioner_unit.sv
sim/testbench.sv
